[sv/nearest_match_velocity_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nearest match velocity tracker
// Clocked concurrent checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef NEAREST_MATCH_VELOCITY_TRACKER_MACROS_SVH
`define NEAREST_MATCH_VELOCITY_TRACKER_MACROS_SVH

// Check that an expression holds at every rising clock edge
`define NMVT_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define NMVT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

[sv/nmvt_pkg.sv]
// ----------------------------------------------------------------------------
// nmvt_pkg
// Shared constants and types of the nearest match velocity tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nmvt_pkg;

   // table geometry
   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [15:0]       coord_type;

   // request opcodes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_FRAME = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOREF = 2'd1;
   localparam logic [1:0] ST_SKIP  = 2'd2;

   // register indexes and reset values
   localparam logic [1:0] REG_JUMP = 2'd0;
   localparam logic [1:0] REG_PPM  = 2'd1;
   localparam logic [1:0] REG_GRES = 2'd2;
   localparam logic [15:0] JT_RST  = 16'd128;
   localparam logic [7:0]  PPM_RST = 8'd50;
   localparam logic [15:0] GR_RST  = 16'd3277;

   // microseconds per second
   localparam logic [31:0] US_PER_S = 32'd1000000;

   // datapath widths
   localparam int D2_W   = 33;  // squared distance, Q.8
   localparam int SQ_W   = 50;  // radicand, padded to whole bit pairs
   localparam int ROOT_W = 25;  // distance, Q.12
   localparam int SQR_W  = 28;  // square root remainder
   localparam int DEN_W  = 44;  // divisor
   localparam int REM_W  = 48;  // division remainder
   localparam logic [5:0] SQRT_STEPS = 6'd25;
   localparam logic [5:0] DIV_STEPS  = 6'd32;

endpackage

`default_nettype wire

[sv/nearest_match_velocity_tracker.sv]
// ----------------------------------------------------------------------------
// nearest_match_velocity_tracker
// Matches query circles to the nearest circle of the previous frame and
// reports speed and velocity, using one shared multiplier and shift/subtract
// steps for square root and division.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  request  | start / busy           | req_opcode .. req_circle_count
//  result   | rsp_strobe (1 cycle)   | rsp_matched_slot .. rsp_status
//  config   | csr_valid / csr_ready  | csr_index, csr_data
//
//  Load: busy stays low. Begin frame: busy while the table is copied.
//  Query: busy while it searches the snapshot, takes the square root, tests for a
//  jump, runs the multiplier steps and up to three divisions (the speed division is
//  skipped on a jump), then delivers; the result follows in the cycle after.
//  A skipped query answers in the next cycle, an empty snapshot after the search.
//  Synchronous reset empties both tables; results cannot stall, csr_ready high idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_match_velocity_tracker_macros.svh"

module nearest_match_velocity_tracker (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [3:0]          req_slot,
   input  wire logic [15:0]         req_center_x,
   input  wire logic [15:0]         req_center_y,
   input  wire logic [31:0]         req_timestamp,
   input  wire logic [4:0]          req_circle_count,
   output logic                     rsp_strobe,
   output logic [3:0]               rsp_matched_slot,
   output logic [31:0]              rsp_speed,
   output logic signed [31:0]       rsp_vel_x,
   output logic signed [31:0]       rsp_vel_y,
   output logic                     rsp_jumped,
   output logic [1:0]               rsp_status,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_data
);

   localparam int NS = nmvt_pkg::NUM_SLOTS;
   localparam int SW = nmvt_pkg::SLOT_W;
   localparam int CW = nmvt_pkg::CNT_W;
   localparam nmvt_pkg::slot_type LAST_SLOT = SW'(NS - 1);

   // sequencer states
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_SNAP   = 5'd1;
   localparam logic [4:0] S_DIFF   = 5'd2;
   localparam logic [4:0] S_SQX    = 5'd3;
   localparam logic [4:0] S_SQY    = 5'd4;
   localparam logic [4:0] S_CMP    = 5'd5;
   localparam logic [4:0] S_SEND   = 5'd6;
   localparam logic [4:0] S_SQRT   = 5'd7;
   localparam logic [4:0] S_LIM    = 5'd8;
   localparam logic [4:0] S_LIMSQ  = 5'd9;
   localparam logic [4:0] S_JTEST  = 5'd10;
   localparam logic [4:0] S_JSPD   = 5'd11;
   localparam logic [4:0] S_JSET   = 5'd12;
   localparam logic [4:0] S_DG     = 5'd13;
   localparam logic [4:0] S_NHI    = 5'd14;
   localparam logic [4:0] S_NLO    = 5'd15;
   localparam logic [4:0] S_NSUM   = 5'd16;
   localparam logic [4:0] S_SCHK   = 5'd17;
   localparam logic [4:0] S_DIV    = 5'd18;
   localparam logic [4:0] S_VSTART = 5'd19;
   localparam logic [4:0] S_MVX    = 5'd20;
   localparam logic [4:0] S_LVX    = 5'd21;
   localparam logic [4:0] S_MVY    = 5'd22;
   localparam logic [4:0] S_LVY    = 5'd23;
   localparam logic [4:0] S_OUT    = 5'd24;

   // division jobs
   localparam logic [1:0] JOB_SPD = 2'd0;
   localparam logic [1:0] JOB_VX  = 2'd1;
   localparam logic [1:0] JOB_VY  = 2'd2;

   // control state
   logic [4:0]          state_ff, state_in;
   nmvt_pkg::slot_type  idx_ff, idx_in;
   nmvt_pkg::slot_type  qi_ff, qi_in;
   logic [CW-1:0]       snap_cnt_ff, snap_cnt_in;
   logic                skip_ff, skip_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [1:0]          job_ff, job_in;

   // configuration
   logic [15:0]         jt_ff, jt_in;
   logic [7:0]          ppm_ff, ppm_in;
   logic [15:0]         gr_ff, gr_in;

   // table and snapshot
   nmvt_pkg::coord_type ref_x_ff [NS];
   nmvt_pkg::coord_type ref_x_in [NS];
   nmvt_pkg::coord_type ref_y_ff [NS];
   nmvt_pkg::coord_type ref_y_in [NS];
   logic [31:0]         ref_t_ff [NS];
   logic [31:0]         ref_t_in [NS];
   logic [NS-1:0]       ref_v_ff, ref_v_in;
   nmvt_pkg::coord_type snap_x_ff [NS];
   nmvt_pkg::coord_type snap_x_in [NS];
   nmvt_pkg::coord_type snap_y_ff [NS];
   nmvt_pkg::coord_type snap_y_in [NS];
   logic [NS-1:0]       snap_v_ff, snap_v_in;

   // request fields
   logic [15:0]         cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0]         ts_ff, ts_in;
   logic [4:0]          cc_ff, cc_in;

   // search
   logic [15:0]         adx_ff, adx_in, ady_ff, ady_in;
   logic                sx_ff, sx_in, sy_ff, sy_in;
   logic                found_ff, found_in;
   nmvt_pkg::slot_type  best_ff, best_in;
   logic [nmvt_pkg::D2_W-1:0] best_d2_ff, best_d2_in;
   logic [15:0]         badx_ff, badx_in, bady_ff, bady_in;
   logic                bsx_ff, bsx_in, bsy_ff, bsy_in;

   // shared multiplier
   logic [31:0]         mul_a, mul_b;
   logic [63:0]         mul_prod;
   logic [63:0]         mul_p_ff, mul_p_in;
   logic [63:0]         acc_ff, acc_in;

   // square root
   logic [nmvt_pkg::SQ_W-1:0]   sq_v_ff, sq_v_in;
   logic [nmvt_pkg::SQR_W-1:0]  sq_r_ff, sq_r_in;
   logic [nmvt_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [nmvt_pkg::SQR_W-1:0]  sq_rem2, sq_trial;

   // divider
   logic [nmvt_pkg::REM_W-1:0]  dv_rem_ff, dv_rem_in, dv_rem2;
   logic [31:0]                 dv_q_ff, dv_q_in;
   logic [nmvt_pkg::DEN_W-1:0]  dv_den_ff, dv_den_in;
   logic                        dv_ge;
   logic                        dv_go;
   logic [63:0]                 dv_num;
   logic [nmvt_pkg::DEN_W-1:0]  dv_den;

   // results
   logic                jmp_ff, jmp_in;
   logic [31:0]         speed_ff, speed_in;
   logic [31:0]         qx_ff, qx_in, qy_ff, qy_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [3:0]          rsp_slot_ff, rsp_slot_in;
   logic [31:0]         rsp_speed_ff, rsp_speed_in;
   logic [31:0]         rsp_vx_ff, rsp_vx_in, rsp_vy_ff, rsp_vy_in;
   logic                rsp_jmp_ff, rsp_jmp_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   // datapath helpers
   logic [16:0]         dx_s, dy_s;
   logic [nmvt_pkg::D2_W-1:0] d2_sum;
   logic [31:0]         ref_t_q, dt;

   // signed saturation of a magnitude with a sign
   function automatic logic [31:0] sat_signed(input logic [31:0] mag, input logic neg);
      logic [31:0] res;
      if (neg) begin
         res = mag[31] ? 32'h8000_0000 : (32'd0 - mag);
      end else begin
         res = mag[31] ? 32'h7FFF_FFFF : mag;
      end
      return res;
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign mul_prod  = mul_a * mul_b;

   // difference to the snapshot entry under search
   assign dx_s   = {1'b0, cx_ff} - {1'b0, snap_x_ff[idx_ff]};
   assign dy_s   = {1'b0, cy_ff} - {1'b0, snap_y_ff[idx_ff]};
   assign d2_sum = {1'b0, acc_ff[31:0]} + {1'b0, mul_p_ff[31:0]};

   // elapsed time since the query slot was written
   assign ref_t_q = ref_v_ff[qi_ff] ? ref_t_ff[qi_ff] : 32'd0;
   assign dt      = ts_ff - ref_t_q;

   // one square root step: two radicand bits in, one root bit out
   assign sq_rem2  = {sq_r_ff[nmvt_pkg::SQR_W-3:0],
                      sq_v_ff[nmvt_pkg::SQ_W-1:nmvt_pkg::SQ_W-2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};

   // one division step: one dividend bit in, one quotient bit out
   assign dv_rem2 = {dv_rem_ff[nmvt_pkg::REM_W-2:0], dv_q_ff[31]};
   assign dv_ge   = (dv_rem2 >= {{(nmvt_pkg::REM_W - nmvt_pkg::DEN_W){1'b0}}, dv_den_ff});

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      qi_in       = qi_ff;
      snap_cnt_in = snap_cnt_ff;
      skip_in     = skip_ff;
      cnt_in      = cnt_ff;
      job_in      = job_ff;
      jt_in       = jt_ff;
      ppm_in      = ppm_ff;
      gr_in       = gr_ff;
      ref_x_in    = ref_x_ff;
      ref_y_in    = ref_y_ff;
      ref_t_in    = ref_t_ff;
      ref_v_in    = ref_v_ff;
      snap_x_in   = snap_x_ff;
      snap_y_in   = snap_y_ff;
      snap_v_in   = snap_v_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      ts_in       = ts_ff;
      cc_in       = cc_ff;
      adx_in      = adx_ff;
      ady_in      = ady_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_d2_in  = best_d2_ff;
      badx_in     = badx_ff;
      bady_in     = bady_ff;
      bsx_in      = bsx_ff;
      bsy_in      = bsy_ff;
      mul_a       = 32'd0;
      mul_b       = 32'd0;
      acc_in      = acc_ff;
      sq_v_in     = sq_v_ff;
      sq_r_in     = sq_r_ff;
      root_in     = root_ff;
      dv_rem_in   = dv_rem_ff;
      dv_q_in     = dv_q_ff;
      dv_den_in   = dv_den_ff;
      dv_go       = 1'b0;
      dv_num      = acc_ff;
      dv_den      = {dt, 12'd0};
      jmp_in      = jmp_ff;
      speed_in    = speed_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      rsp_strobe_in = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_speed_in  = rsp_speed_ff;
      rsp_vx_in     = rsp_vx_ff;
      rsp_vy_in     = rsp_vy_ff;
      rsp_jmp_in    = rsp_jmp_ff;
      rsp_status_in = rsp_status_ff;

      // take register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            nmvt_pkg::REG_JUMP: jt_in  = csr_data;
            nmvt_pkg::REG_PPM:  ppm_in = csr_data[7:0];
            nmvt_pkg::REG_GRES: gr_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cx_in = req_center_x;
               cy_in = req_center_y;
               ts_in = req_timestamp;
               cc_in = req_circle_count;
               case (req_opcode)
                  nmvt_pkg::OP_LOAD: begin
                     if (32'(req_slot) < NS) begin
                        ref_x_in[SW'(req_slot)] = req_center_x;
                        ref_y_in[SW'(req_slot)] = req_center_y;
                        ref_t_in[SW'(req_slot)] = req_timestamp;
                        ref_v_in[SW'(req_slot)] = 1'b1;
                     end
                  end
                  nmvt_pkg::OP_FRAME: begin
                     idx_in      = '0;
                     snap_cnt_in = '0;
                     state_in    = S_SNAP;
                  end
                  nmvt_pkg::OP_QUERY: begin
                     if (skip_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_slot_in   = 4'd0;
                        rsp_speed_in  = 32'd0;
                        rsp_vx_in     = 32'd0;
                        rsp_vy_in     = 32'd0;
                        rsp_jmp_in    = 1'b0;
                        rsp_status_in = nmvt_pkg::ST_SKIP;
                     end else begin
                        idx_in   = '0;
                        found_in = 1'b0;
                        state_in = S_DIFF;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // copy the table one slot a cycle and count valid entries
         S_SNAP: begin
            snap_x_in[idx_ff] = ref_x_ff[idx_ff];
            snap_y_in[idx_ff] = ref_y_ff[idx_ff];
            snap_v_in[idx_ff] = ref_v_ff[idx_ff];
            snap_cnt_in = snap_cnt_ff + CW'(ref_v_ff[idx_ff]);
            if (idx_ff == LAST_SLOT) begin
               skip_in  = 32'(cc_ff) > 32'(snap_cnt_in);
               qi_in    = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // search: absolute differences of a valid entry, or skip it
         S_DIFF: begin
            if (snap_v_ff[idx_ff]) begin
               sx_in    = dx_s[16];
               sy_in    = dy_s[16];
               adx_in   = dx_s[16] ? 16'(17'd0 - dx_s) : dx_s[15:0];
               ady_in   = dy_s[16] ? 16'(17'd0 - dy_s) : dy_s[15:0];
               state_in = S_SQX;
            end else if (idx_ff == LAST_SLOT) begin
               state_in = S_SEND;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_SQX: begin
            mul_a    = {16'd0, adx_ff};
            mul_b    = {16'd0, adx_ff};
            state_in = S_SQY;
         end

         S_SQY: begin
            acc_in   = mul_p_ff;
            mul_a    = {16'd0, ady_ff};
            mul_b    = {16'd0, ady_ff};
            state_in = S_CMP;
         end

         // keep the first strict minimum
         S_CMP: begin
            if (!found_ff || (d2_sum < best_d2_ff)) begin
               found_in   = 1'b1;
               best_in    = idx_ff;
               best_d2_in = d2_sum;
               badx_in    = adx_ff;
               bady_in    = ady_ff;
               bsx_in     = sx_ff;
               bsy_in     = sy_ff;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = S_SEND;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_DIFF;
            end
         end

         // empty snapshot answers at once, else start the square root
         S_SEND: begin
            if (!found_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = 4'd0;
               rsp_speed_in  = 32'd0;
               rsp_vx_in     = 32'd0;
               rsp_vy_in     = 32'd0;
               rsp_jmp_in    = 1'b0;
               rsp_status_in = nmvt_pkg::ST_NOREF;
               state_in      = S_IDLE;
            end else begin
               sq_v_in  = nmvt_pkg::SQ_W'({best_d2_ff, 16'd0});
               sq_r_in  = '0;
               root_in  = '0;
               cnt_in   = nmvt_pkg::SQRT_STEPS;
               state_in = S_SQRT;
            end
         end

         S_SQRT: begin
            if (cnt_ff == 6'd0) begin
               state_in = S_LIM;
            end else begin
               if (sq_rem2 >= sq_trial) begin
                  sq_r_in = sq_rem2 - sq_trial;
                  root_in = {root_ff[nmvt_pkg::ROOT_W-2:0], 1'b1};
               end else begin
                  sq_r_in = sq_rem2;
                  root_in = {root_ff[nmvt_pkg::ROOT_W-2:0], 1'b0};
               end
               sq_v_in = {sq_v_ff[nmvt_pkg::SQ_W-3:0], 2'b00};
               cnt_in  = cnt_ff - 1'b1;
            end
         end

         // jump limit: (threshold * pixels_per_meter)^2
         S_LIM: begin
            mul_a    = {16'd0, jt_ff};
            mul_b    = {24'd0, ppm_ff};
            state_in = S_LIMSQ;
         end

         S_LIMSQ: begin
            mul_a    = {8'd0, mul_p_ff[23:0]};
            mul_b    = {8'd0, mul_p_ff[23:0]};
            state_in = S_JTEST;
         end

         S_JTEST: begin
            jmp_in   = {7'd0, best_d2_ff, 8'd0} > mul_p_ff[47:0];
            state_in = jmp_in ? S_JSPD : S_DG;
         end

         S_JSPD: begin
            mul_a    = {24'd0, ppm_ff};
            mul_b    = {16'd0, gr_ff};
            state_in = S_JSET;
         end

         S_JSET: begin
            speed_in = mul_p_ff[31:0];
            state_in = S_VSTART;
         end

         // numerator dist * resolution * 1e6, split into a 20-bit low and a 21-bit high part
         S_DG: begin
            mul_a    = {7'd0, root_ff};
            mul_b    = {16'd0, gr_ff};
            state_in = S_NHI;
         end

         S_NHI: begin
            acc_in   = {44'd0, mul_p_ff[19:0]};
            mul_a    = {11'd0, mul_p_ff[40:20]};
            mul_b    = nmvt_pkg::US_PER_S;
            state_in = S_NLO;
         end

         S_NLO: begin
            acc_in   = mul_p_ff;
            mul_a    = {12'd0, acc_ff[19:0]};
            mul_b    = nmvt_pkg::US_PER_S;
            state_in = S_NSUM;
         end

         S_NSUM: begin
            acc_in   = {acc_ff[43:0], 20'd0} + mul_p_ff;
            state_in = S_SCHK;
         end

         // speed = num / (dt * 4096)
         S_SCHK: begin
            if (acc_ff == 64'd0) begin
               speed_in = 32'd0;
               state_in = S_VSTART;
            end else begin
               dv_go  = 1'b1;
               job_in = JOB_SPD;
            end
         end

         S_DIV: begin
            if (cnt_ff == 6'd0) begin
               case (job_ff)
                  JOB_SPD: begin
                     speed_in = dv_q_ff;
                     state_in = S_VSTART;
                  end
                  JOB_VX: begin
                     qx_in    = dv_q_ff;
                     state_in = S_MVY;
                  end
                  default: begin
                     qy_in    = dv_q_ff;
                     state_in = S_OUT;
                  end
               endcase
            end else begin
               dv_rem_in = dv_ge ? (dv_rem2 - {4'd0, dv_den_ff}) : dv_rem2;
               dv_q_in   = {dv_q_ff[30:0], dv_ge};
               cnt_in    = cnt_ff - 1'b1;
            end
         end

         // zero distance points along +x
         S_VSTART: begin
            if (root_ff == '0) begin
               qx_in    = speed_ff;
               qy_in    = 32'd0;
               state_in = S_OUT;
            end else begin
               state_in = S_MVX;
            end
         end

         S_MVX: begin
            mul_a    = speed_ff;
            mul_b    = {8'd0, badx_ff, 8'd0};
            state_in = S_LVX;
         end

         S_LVX: begin
            dv_go  = 1'b1;
            dv_num = mul_p_ff;
            dv_den = {19'd0, root_ff};
            job_in = JOB_VX;
         end

         S_MVY: begin
            mul_a    = speed_ff;
            mul_b    = {8'd0, bady_ff, 8'd0};
            state_in = S_LVY;
         end

         S_LVY: begin
            dv_go  = 1'b1;
            dv_num = mul_p_ff;
            dv_den = {19'd0, root_ff};
            job_in = JOB_VY;
         end

         // deliver and overwrite the query slot
         S_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_slot_in   = 4'(best_ff);
            rsp_speed_in  = speed_ff;
            rsp_vx_in     = sat_signed(qx_ff, bsx_ff);
            rsp_vy_in     = sat_signed(qy_ff, bsy_ff);
            rsp_jmp_in    = jmp_ff;
            rsp_status_in = nmvt_pkg::ST_OK;
            ref_x_in[qi_ff] = cx_ff;
            ref_y_in[qi_ff] = cy_ff;
            ref_t_in[qi_ff] = ts_ff;
            ref_v_in[qi_ff] = 1'b1;
            qi_in    = (qi_ff == LAST_SLOT) ? '0 : qi_ff + 1'b1;
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      // load the divider; a quotient past 32 bits saturates at once
      if (dv_go) begin
         dv_den_in = dv_den;
         state_in  = S_DIV;
         if ({12'd0, dv_num[63:32]} >= dv_den) begin
            dv_q_in = 32'hFFFF_FFFF;
            cnt_in  = 6'd0;
         end else begin
            dv_rem_in = {16'd0, dv_num[63:32]};
            dv_q_in   = dv_num[31:0];
            cnt_in    = nmvt_pkg::DIV_STEPS;
         end
      end

      mul_p_in = mul_prod;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         qi_ff         <= '0;
         snap_cnt_ff   <= '0;
         skip_ff       <= 1'b0;
         ref_v_ff      <= '0;
         snap_v_ff     <= '0;
         jt_ff         <= nmvt_pkg::JT_RST;
         ppm_ff        <= nmvt_pkg::PPM_RST;
         gr_ff         <= nmvt_pkg::GR_RST;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         qi_ff         <= qi_in;
         snap_cnt_ff   <= snap_cnt_in;
         skip_ff       <= skip_in;
         ref_v_ff      <= ref_v_in;
         snap_v_ff     <= snap_v_in;
         jt_ff         <= jt_in;
         ppm_ff        <= ppm_in;
         gr_ff         <= gr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      job_ff     <= job_in;
      ref_x_ff   <= ref_x_in;
      ref_y_ff   <= ref_y_in;
      ref_t_ff   <= ref_t_in;
      snap_x_ff  <= snap_x_in;
      snap_y_ff  <= snap_y_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      ts_ff      <= ts_in;
      cc_ff      <= cc_in;
      adx_ff     <= adx_in;
      ady_ff     <= ady_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      best_d2_ff <= best_d2_in;
      badx_ff    <= badx_in;
      bady_ff    <= bady_in;
      bsx_ff     <= bsx_in;
      bsy_ff     <= bsy_in;
      mul_p_ff   <= mul_p_in;
      acc_ff     <= acc_in;
      sq_v_ff    <= sq_v_in;
      sq_r_ff    <= sq_r_in;
      root_ff    <= root_in;
      dv_rem_ff  <= dv_rem_in;
      dv_q_ff    <= dv_q_in;
      dv_den_ff  <= dv_den_in;
      jmp_ff     <= jmp_in;
      speed_ff   <= speed_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_speed_ff  <= rsp_speed_in;
      rsp_vx_ff     <= rsp_vx_in;
      rsp_vy_ff     <= rsp_vy_in;
      rsp_jmp_ff    <= rsp_jmp_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_matched_slot = rsp_slot_ff;
   assign rsp_speed        = rsp_speed_ff;
   assign rsp_vel_x        = rsp_vx_ff;
   assign rsp_vel_y        = rsp_vy_ff;
   assign rsp_jumped       = rsp_jmp_ff;
   assign rsp_status       = rsp_status_ff;

   // checks
   `NMVT_ASSERT_IMPL(a_status_clears_payload, rsp_strobe && (rsp_status != nmvt_pkg::ST_OK), (rsp_speed == 32'd0) && (rsp_vel_x == 32'sd0) && (rsp_vel_y == 32'sd0) && !rsp_jumped && (rsp_matched_slot == 4'd0), "status result carries a payload")
   `NMVT_ASSERT_IMPL(a_ok_after_work, rsp_strobe && (rsp_status == nmvt_pkg::ST_OK), $past(busy), "ok result without a served query")
   `NMVT_ASSERT_ALWAYS(a_qi_moves_on_ok, (qi_ff == $past(qi_ff)) || (qi_ff == '0) || (rsp_strobe && (rsp_status == nmvt_pkg::ST_OK)), "query slot moved without a served query")

endmodule

`default_nettype wire

[bench/nearest_match_velocity_tracker_tb.sv]
// ----------------------------------------------------------------------------
// nearest_match_velocity_tracker_tb
// Drives loads, frame starts, query circles, unused opcodes and register writes
// into the tracker. A scoreboard predicts the match, speed, velocity and status
// of every query and compares each strobed result against them, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_match_velocity_tracker_tb;

   // opcode that the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  opcode;
      logic [3:0]  slot;
      logic [15:0] cx;
      logic [15:0] cy;
      logic [31:0] ts;
      logic [4:0]  count;
   } request_type;

   typedef struct {
      logic [3:0]  slot;
      logic [31:0] speed;
      logic [31:0] vx;
      logic [31:0] vy;
      logic        jumped;
      logic [1:0]  status;
   } report_type;

   // Predicts each query report from its own copy of table and registers
   class track_scoreboard;
      logic [15:0] jump_lim, ppm, gres;
      logic [15:0] tab_x [nmvt_pkg::NUM_SLOTS];
      logic [15:0] tab_y [nmvt_pkg::NUM_SLOTS];
      logic [31:0] tab_t [nmvt_pkg::NUM_SLOTS];
      bit          tab_v [nmvt_pkg::NUM_SLOTS];
      logic [15:0] snp_x [nmvt_pkg::NUM_SLOTS];
      logic [15:0] snp_y [nmvt_pkg::NUM_SLOTS];
      bit          snp_v [nmvt_pkg::NUM_SLOTS];
      int          next_query;
      bit          skipping;
      report_type  pending[$];
      int          mismatches;

      function new();
         jump_lim = nmvt_pkg::JT_RST; ppm = {8'd0, nmvt_pkg::PPM_RST};
         gres = nmvt_pkg::GR_RST;
         for (int i = 0; i < nmvt_pkg::NUM_SLOTS; i++) begin
            tab_x[i] = 0; tab_y[i] = 0; tab_t[i] = 0; tab_v[i] = 0;
            snp_x[i] = 0; snp_y[i] = 0; snp_v[i] = 0;
         end
         next_query = 0; skipping = 0; mismatches = 0;
      endfunction

      // queue one expected report
      function void post_report(report_type rep);
         pending.insert(pending.size(), rep);
      endfunction

      function void note_config(logic [1:0] idx, logic [15:0] data);
         case (idx)
            nmvt_pkg::REG_JUMP: jump_lim = data;
            nmvt_pkg::REG_PPM:  ppm = {8'd0, data[7:0]};
            nmvt_pkg::REG_GRES: gres = data;
            default: ;
         endcase
      endfunction

      function longint unsigned int_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      function logic [31:0] clamp_signed(longint unsigned mag, bit neg);
         if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
         return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      endfunction

      function void note_request(request_type r);
         report_type      rep;
         int              cnt, best, qi;
         bit              found, jmp;
         longint          dx, dy;
         longint unsigned d2, bestd, root_len, lim, num, speed;
         logic [31:0]     dt;
         cnt = 0; best = 0; found = 0; bestd = 0;
         rep = '{slot: 0, speed: 0, vx: 0, vy: 0, jumped: 0, status: nmvt_pkg::ST_OK};
         case (r.opcode)
            nmvt_pkg::OP_LOAD: begin
               tab_x[r.slot] = r.cx; tab_y[r.slot] = r.cy;
               tab_t[r.slot] = r.ts; tab_v[r.slot] = 1;
            end
            nmvt_pkg::OP_FRAME: begin
               for (int i = 0; i < nmvt_pkg::NUM_SLOTS; i++) begin
                  snp_x[i] = tab_x[i]; snp_y[i] = tab_y[i]; snp_v[i] = tab_v[i];
                  if (tab_v[i]) cnt++;
               end
               skipping = r.count > cnt;
               next_query = 0;
            end
            nmvt_pkg::OP_QUERY: begin
               if (skipping) begin
                  rep.status = nmvt_pkg::ST_SKIP;
                  post_report(rep);
                  return;
               end
               // search the snapshot, first strict minimum wins
               for (int i = 0; i < nmvt_pkg::NUM_SLOTS; i++) begin
                  if (snp_v[i]) begin
                     dx = longint'(r.cx) - longint'(snp_x[i]);
                     dy = longint'(r.cy) - longint'(snp_y[i]);
                     d2 = dx * dx + dy * dy;
                     if (!found || d2 < bestd) begin
                        bestd = d2; best = i; found = 1;
                     end
                  end
               end
               if (!found) begin
                  rep.status = nmvt_pkg::ST_NOREF;
                  post_report(rep);
                  return;
               end
               dx = longint'(r.cx) - longint'(snp_x[best]);
               dy = longint'(r.cy) - longint'(snp_y[best]);
               root_len = int_root(bestd << 16);
               lim = longint'(jump_lim) * longint'(ppm);
               jmp = (bestd << 8) > lim * lim;
               qi = next_query;
               if (jmp) speed = longint'(ppm) * longint'(gres);
               else begin
                  num = root_len * 64'd1000000 * longint'(gres);
                  dt = r.ts - tab_t[qi];
                  if (num == 0) speed = 0;
                  else if (dt == 0) speed = 64'hFFFF_FFFF;
                  else begin
                     speed = num / (longint'(dt) * 64'd4096);
                     if (speed > 64'hFFFF_FFFF) speed = 64'hFFFF_FFFF;
                  end
               end
               if (root_len == 0) rep.vx = clamp_signed(speed, 0);
               else begin
                  rep.vx = clamp_signed(speed * ((dx < 0 ? -dx : dx) * 256) / root_len,
                                        dx < 0);
                  rep.vy = clamp_signed(speed * ((dy < 0 ? -dy : dy) * 256) / root_len,
                                        dy < 0);
               end
               rep.slot = best[3:0];
               rep.speed = speed[31:0];
               rep.jumped = jmp;
               post_report(rep);
               // overwrite the query's own slot
               tab_x[qi] = r.cx; tab_y[qi] = r.cy; tab_t[qi] = r.ts; tab_v[qi] = 1;
               next_query = (qi + 1) % nmvt_pkg::NUM_SLOTS;
            end
            default: ;
         endcase
      endfunction

      function void check_result(report_type got);
         report_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: slot %0d status %0d",
                                           got.slot, got.status);
            return;
         end
         want = pending.pop_front();
         if (got.slot !== want.slot || got.speed !== want.speed || got.vx !== want.vx ||
             got.vy !== want.vy || got.jumped !== want.jumped ||
             got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch exp: slot %0d speed %h vx %h vy %h jump %b status %0d",
                        want.slot, want.speed, want.vx, want.vy, want.jumped, want.status);
               $display("         got: slot %0d speed %h vx %h vy %h jump %b status %0d",
                        got.slot, got.speed, got.vx, got.vy, got.jumped, got.status);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_opcode = 0;
   logic [3:0]  req_slot = 0;
   logic [15:0] req_center_x = 0;
   logic [15:0] req_center_y = 0;
   logic [31:0] req_timestamp = 0;
   logic [4:0]  req_circle_count = 0;
   logic        rsp_strobe;
   logic [3:0]  rsp_matched_slot;
   logic [31:0] rsp_speed;
   logic signed [31:0] rsp_vel_x, rsp_vel_y;
   logic        rsp_jumped;
   logic [1:0]  rsp_status;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_data = 0;

   track_scoreboard sb = new();
   int          quiet_cycles = 0;
   logic [31:0] clock_us = 0;

   nearest_match_velocity_tracker dut (.*);

   always #4 clock = ~clock;

   // Check strobed results and watch for a stalled run
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_result('{slot: rsp_matched_slot, speed: rsp_speed, vx: rsp_vel_x,
                              vy: rsp_vel_y, jumped: rsp_jumped, status: rsp_status});
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= 20000) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Present one request after a random idle stretch, hold until taken
   task automatic send(request_type r, int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start = 0;
      end
      @(negedge clock);
      req_opcode = r.opcode; req_slot = r.slot;
      req_center_x = r.cx; req_center_y = r.cy;
      req_timestamp = r.ts; req_circle_count = r.count;
      start = 1;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   // Hold off until every report is back and the block has settled
   task automatic drain();
      @(negedge clock);
      start = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_valid = 1; csr_index = idx; csr_data = data;
      do @(posedge clock); while (!csr_ready);
      sb.note_config(idx, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic request_type make_req(logic [1:0] op, logic [3:0] s, logic [15:0] x,
                                            logic [15:0] y, logic [31:0] t, logic [4:0] c);
      request_type r;
      r.opcode = op; r.slot = s; r.cx = x; r.cy = y; r.ts = t; r.count = c;
      return r;
   endfunction

   function automatic logic [15:0] pick_coord();
      if ($urandom_range(0, 9) < 2) return 16'($urandom);
      return 16'h4000 + 16'($urandom_range(0, 2047));
   endfunction

   function automatic request_type random_req();
      int          roll;
      request_type r;
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
         0:       clock_us = $urandom;
         1:       ;
         default: clock_us = clock_us + $urandom_range(1, 5000);
      endcase
      r = make_req(nmvt_pkg::OP_QUERY, 4'($urandom), pick_coord(), pick_coord(), clock_us,
                   5'($urandom_range(0, 16)));
      if (roll < 10) r.opcode = nmvt_pkg::OP_LOAD;
      else if (roll < 18) r.opcode = nmvt_pkg::OP_FRAME;
      else if (roll < 22) r.opcode = OP_UNUSED;
      return r;
   endfunction

   initial begin
      int idle_pct;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: skip on empty table, empty snapshot, extremes, zero time
      send(make_req(nmvt_pkg::OP_FRAME, 0, 0, 0, 0, 5'd1), 0);
      send(make_req(nmvt_pkg::OP_QUERY, 0, 16'h1234, 16'h5678, 32'd10, 0), 0);
      send(make_req(nmvt_pkg::OP_FRAME, 0, 0, 0, 0, 5'd0), 0);
      send(make_req(nmvt_pkg::OP_QUERY, 0, 16'h1234, 16'h5678, 32'd10, 0), 0);
      send(make_req(nmvt_pkg::OP_LOAD, 4'd0, 16'h0000, 16'h0000, 32'd0, 0), 0);
      send(make_req(nmvt_pkg::OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0), 0);
      send(make_req(OP_UNUSED, 4'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31), 0);
      send(make_req(nmvt_pkg::OP_FRAME, 0, 0, 0, 0, 5'd16), 0);
      send(make_req(nmvt_pkg::OP_QUERY, 0, 16'h0000, 16'h0000, 32'd0, 0), 0);
      send(make_req(nmvt_pkg::OP_FRAME, 0, 0, 0, 0, 5'd2), 0);
      send(make_req(nmvt_pkg::OP_QUERY, 0, 16'h0000, 16'h0000, 32'd0, 0), 0);
      send(make_req(nmvt_pkg::OP_QUERY, 0, 16'h0010, 16'h0000, 32'd0, 0), 0);
      send(make_req(nmvt_pkg::OP_QUERY, 0, 16'hFFF0, 16'h0008, 32'd5, 0), 0);
      send(make_req(nmvt_pkg::OP_QUERY, 0, 16'h0003, 16'h0004, 32'hFFFF_FFFF, 0), 0);
      send(make_req(nmvt_pkg::OP_QUERY, 0, 16'h7FFF, 16'h8000, 32'h8000_0000, 0), 0);
      for (int i = 1; i < nmvt_pkg::NUM_SLOTS - 1; i++)
         send(make_req(nmvt_pkg::OP_LOAD, 4'(i), 16'h4000 + 16'(i * 64),
                       16'h4000 - 16'(i * 32), 32'(i * 1000), 0), 0);
      drain();

      // random phases, each under its own register setting
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               write_reg(nmvt_pkg::REG_JUMP, 16'hFFFF); write_reg(nmvt_pkg::REG_PPM, 16'h00FF);
               write_reg(nmvt_pkg::REG_GRES, 16'hFFFF); idle_pct = 33;
            end
            1: begin
               write_reg(nmvt_pkg::REG_JUMP, 16'h0000); write_reg(nmvt_pkg::REG_PPM, 16'h0001);
               write_reg(nmvt_pkg::REG_GRES, 16'h0001); idle_pct = 78;
            end
            default: begin
               write_reg(nmvt_pkg::REG_JUMP, 16'h0100); write_reg(nmvt_pkg::REG_PPM, 16'h0000);
               write_reg(nmvt_pkg::REG_GRES, 16'h0CCD); idle_pct = 0;
            end
         endcase
         for (int n = 0; n < 420; n++) begin
            send(random_req(), idle_pct);
            if ($urandom_range(0, 99) == 0) drain();
         end
         drain();
      end
      write_reg(nmvt_pkg::REG_JUMP, nmvt_pkg::JT_RST);
      write_reg(nmvt_pkg::REG_PPM, {8'd0, nmvt_pkg::PPM_RST});
      write_reg(nmvt_pkg::REG_GRES, nmvt_pkg::GR_RST);
      for (int n = 0; n < 60; n++) send(random_req(), 10);
      drain();

      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/nmvt_pkg.sv
sv/nearest_match_velocity_tracker.sv
bench/nearest_match_velocity_tracker_tb.sv
